// ===== rtl/btb2_pkg.sv =====
// Shared types and constants of the branch target buffer.
package btb2_pkg;

	// Fixed field widths of the channels.
	localparam int unsigned PC_W        = 32;
	localparam int unsigned OUTC_W      = 3;
	localparam int unsigned CTR_W       = 2;
	localparam int unsigned TALLY_OUT_W = 16;

	// Distance of a sequential step and the ceiling of the two-bit counter.
	localparam logic [PC_W-1:0]  SEQ_STEP = 32'd4;
	localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;

	// Outcome codes reported with each result.
	typedef enum logic [OUTC_W-1:0] {
		OUT_UNTRACKED = 3'd0,
		OUT_INSERTED  = 3'd1,
		OUT_RIGHT     = 3'd2,
		OUT_WRONG     = 3'd3,
		OUT_FULL      = 3'd4
	} outcome_t;

	// Controller states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOOK   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic lookup;
		logic update;
		logic emit;
	} dp_cmd_t;

endpackage

// ===== rtl/btb2_if.sv =====
// Channel interfaces for the PC pair requests and the result requests.
interface btb2_in_if import btb2_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PC_W-1:0] current_pc;
	logic [PC_W-1:0] next_pc;

	modport source (output valid, output current_pc, output next_pc, input ready);
	modport sink   (input valid, input current_pc, input next_pc, output ready);
endinterface

interface btb2_out_if import btb2_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [OUTC_W-1:0]      outcome;
	logic                   was_hit;
	logic [CTR_W-1:0]       counter_after;
	logic [TALLY_OUT_W-1:0] right_tally;
	logic [TALLY_OUT_W-1:0] wrong_tally;

	modport source (output valid, output outcome, output was_hit, output counter_after,
		output right_tally, output wrong_tally, input ready);
	modport sink   (input valid, input outcome, input was_hit, input counter_after,
		input right_tally, input wrong_tally, output ready);
endinterface

// ===== rtl/branch_target_buffer_2bit.sv =====
// Top level of the branch target buffer with two-bit saturating counters.
//
// pc_pair carries one request per executed instruction: current_pc and the
// next_pc that followed it. result returns exactly one request per pc_pair
// request, in order: outcome, was_hit, counter_after and the two tallies.
// Both channels transfer when valid and ready are high at a rising edge.
//
// Each request passes in order through accept, tag lookup with a registered read
// of the entry memory, update, and load of the output register. A new request
// is accepted only once the previous one has been loaded into the output
// register. The sequence is set by the registered read of the entry memory,
// which has to land before the update.
//
// The output register parts the channels: the next request is accepted and
// processed while a result waits, and it holds in the load step until the
// receiver takes the waiting result.
//
// arst_n clears the fill count and the controller at once, which empties
// the table; no clearing pass is needed. Tags and entries are not reset.
module branch_target_buffer_2bit import btb2_pkg::*; #(
	parameter int unsigned ENTRIES    = 32,
	parameter int unsigned TALLY_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	btb2_in_if.sink    pc_pair,
	btb2_out_if.source result
);

	dp_cmd_t cmd;

	// Sequencing of each request.
	btb2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pc_pair.valid),
		.in_ready  (pc_pair.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// Table storage and update.
	btb2_datapath #(
		.ENTRIES    (ENTRIES),
		.TALLY_BITS (TALLY_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.current_pc    (pc_pair.current_pc),
		.next_pc       (pc_pair.next_pc),
		.outcome       (result.outcome),
		.was_hit       (result.was_hit),
		.counter_after (result.counter_after),
		.right_tally   (result.right_tally),
		.wrong_tally   (result.wrong_tally)
	);

endmodule

// ===== rtl/btb2_ctrl.sv =====
// Sequencing state machine of the branch target buffer.
module btb2_ctrl import btb2_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a result when it is empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state: accept, look up, update, then hand the result over.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath commands decoded from the state.
	always_comb begin
		cmd.latch_in = (state_q == ST_IDLE) && in_valid;
		cmd.lookup   = (state_q == ST_LOOK);
		cmd.update   = (state_q == ST_UPDATE);
		cmd.emit     = (state_q == ST_EMIT) && out_free;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Valid flag of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/btb2_datapath.sv =====
// Tag store, entry memory, update logic and output register of the buffer.
module btb2_datapath import btb2_pkg::*; #(
	parameter int unsigned ENTRIES    = 32,
	parameter int unsigned TALLY_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	input  logic [PC_W-1:0]        current_pc,
	input  logic [PC_W-1:0]        next_pc,
	output logic [OUTC_W-1:0]      outcome,
	output logic                   was_hit,
	output logic [CTR_W-1:0]       counter_after,
	output logic [TALLY_OUT_W-1:0] right_tally,
	output logic [TALLY_OUT_W-1:0] wrong_tally
);

	localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned FILL_W = $clog2(ENTRIES + 1);
	localparam int unsigned EXT_W  = TALLY_BITS + TALLY_OUT_W;
	localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};

	typedef struct packed {
		logic [PC_W-1:0]       target;
		logic [CTR_W-1:0]      counter;
		logic [TALLY_BITS-1:0] right;
		logic [TALLY_BITS-1:0] wrong;
	} entry_t;

	// Saturating increment of a tally.
	function automatic logic [TALLY_BITS-1:0] tally_inc(input logic [TALLY_BITS-1:0] t);
		return (t == TALLY_MAX) ? t : t + 1'b1;
	endfunction

	// Two-bit counter steps with ceiling and floor.
	function automatic logic [CTR_W-1:0] ctr_up(input logic [CTR_W-1:0] c);
		return (c == CTR_MAX) ? c : c + 1'b1;
	endfunction

	function automatic logic [CTR_W-1:0] ctr_down(input logic [CTR_W-1:0] c);
		return (c == '0) ? c : c - 1'b1;
	endfunction

	logic [PC_W-1:0]        cur_q;
	logic [PC_W-1:0]        nxt_q;
	logic [PC_W-1:0]        src_q [ENTRIES];
	entry_t                 mem_q [ENTRIES];
	logic [FILL_W-1:0]      fill_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       idx_q;
	entry_t                 rd_q;

	logic [ENTRIES-1:0]     match_vec;
	logic [IDX_W-1:0]       match_idx;
	logic                   match_any;

	logic                   branch;
	logic                   full;
	entry_t                 new_e;
	logic                   do_write;
	logic                   do_insert;
	logic                   rep;
	outcome_t               outc;
	logic [EXT_W-1:0]       right_ext;
	logic [EXT_W-1:0]       wrong_ext;

	logic [OUTC_W-1:0]      res_outcome_q;
	logic                   res_hit_q;
	logic [CTR_W-1:0]       res_counter_q;
	logic [TALLY_OUT_W-1:0] res_right_q;
	logic [TALLY_OUT_W-1:0] res_wrong_q;
	logic [OUTC_W-1:0]      out_outcome_q;
	logic                   out_hit_q;
	logic [CTR_W-1:0]       out_counter_q;
	logic [TALLY_OUT_W-1:0] out_right_q;
	logic [TALLY_OUT_W-1:0] out_wrong_q;

	// Input capture of the accepted request.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cur_q <= current_pc;
			nxt_q <= next_pc;
		end
	end

	// Parallel tag compare. Entries fill in order, so an entry is valid below the fill level.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = (FILL_W'(i) < fill_q) && (src_q[i] == cur_q);
		end
	end

	// Sources are unique, so at most one entry matches and an OR encoder suffices.
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_idx = match_idx | (match_vec[i] ? IDX_W'(i) : '0);
		end
		match_any = |match_vec;
	end

	// Lookup: register hit, target slot and the entry read.
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_q <= match_any;
			idx_q <= match_any ? match_idx : fill_q[IDX_W-1:0];
			rd_q  <= mem_q[match_idx];
		end
	end

	// Update decision for the looked-up entry.
	always_comb begin
		branch    = (nxt_q != (cur_q + SEQ_STEP));
		full      = (fill_q == FILL_W'(ENTRIES));
		new_e     = rd_q;
		do_write  = 1'b0;
		do_insert = 1'b0;
		rep       = 1'b0;
		outc      = OUT_UNTRACKED;
		priority if (hit_q) begin
			rep      = 1'b1;
			do_write = 1'b1;
			if (!branch) begin
				new_e.counter = ctr_up(rd_q.counter);
				new_e.right   = tally_inc(rd_q.right);
				outc          = OUT_RIGHT;
			end else if (rd_q.target == nxt_q) begin
				new_e.counter = ctr_down(rd_q.counter);
				new_e.right   = tally_inc(rd_q.right);
				outc          = OUT_RIGHT;
			end else begin
				new_e.counter = ctr_up(rd_q.counter);
				new_e.wrong   = tally_inc(rd_q.wrong);
				outc          = OUT_WRONG;
			end
		end else if (branch && !full) begin
			new_e.target  = nxt_q;
			new_e.counter = '0;
			new_e.right   = '0;
			new_e.wrong   = '0;
			do_insert     = 1'b1;
			rep           = 1'b1;
			outc          = OUT_INSERTED;
		end else if (branch) begin
			outc = OUT_FULL;
		end else begin
			outc = OUT_UNTRACKED;
		end
		right_ext = EXT_W'(new_e.right);
		wrong_ext = EXT_W'(new_e.wrong);
	end

	// Entry memory: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.update && (do_write || do_insert)) begin
			mem_q[idx_q] <= new_e;
		end
	end

	// Source tags are written only when a new entry is inserted.
	always_ff @(posedge clk) begin
		if (cmd.update && do_insert) begin
			src_q[idx_q] <= cur_q;
		end
	end

	// Fill level counts the valid entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.update && do_insert) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// Result of the current request; hit, counter and tally fields are zero when no entry is reported.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_outcome_q <= outc;
			res_hit_q     <= hit_q;
			res_counter_q <= rep ? new_e.counter : '0;
			res_right_q   <= rep ? right_ext[TALLY_OUT_W-1:0] : '0;
			res_wrong_q   <= rep ? wrong_ext[TALLY_OUT_W-1:0] : '0;
		end
	end

	// Output register, loaded when the receiver has room.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_outcome_q <= res_outcome_q;
			out_hit_q     <= res_hit_q;
			out_counter_q <= res_counter_q;
			out_right_q   <= res_right_q;
			out_wrong_q   <= res_wrong_q;
		end
	end

	assign outcome       = out_outcome_q;
	assign was_hit       = out_hit_q;
	assign counter_after = out_counter_q;
	assign right_tally   = out_right_q;
	assign wrong_tally   = out_wrong_q;

endmodule

// ===== rtl/btb2_checker.sv =====
// Port-level assertions of the branch target buffer and their bind.
module btb2_checker import btb2_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [OUTC_W-1:0]      outcome,
	input logic                   was_hit,
	input logic [CTR_W-1:0]       counter_after,
	input logic [TALLY_OUT_W-1:0] right_tally,
	input logic [TALLY_OUT_W-1:0] wrong_tally
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(was_hit)
			&& $stable(counter_after) && $stable(right_tally) && $stable(wrong_tally))
		else $error("stalled result changed");

	// Right and wrong outcomes come only from a table hit.
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_RIGHT || outcome == OUT_WRONG) |-> was_hit)
		else $error("right or wrong outcome without a hit");

	// Other outcomes report no hit and a zero counter.
	a_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_UNTRACKED || outcome == OUT_INSERTED
			|| outcome == OUT_FULL) |-> !was_hit && counter_after == '0)
		else $error("hit fields set on a miss outcome");

	// A freshly inserted entry starts with empty tallies.
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OUT_INSERTED |-> right_tally == '0 && wrong_tally == '0)
		else $error("inserted entry with nonzero tally");

	// No result appears in the cycle right after a request is accepted.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early after request");

endmodule

bind branch_target_buffer_2bit btb2_checker u_btb2_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (pc_pair.valid),
	.in_ready      (pc_pair.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.outcome       (result.outcome),
	.was_hit       (result.was_hit),
	.counter_after (result.counter_after),
	.right_tally   (result.right_tally),
	.wrong_tally   (result.wrong_tally)
);
